// ===== rtl/fnn_pkg.sv =====
// Shared types, constants and helpers for the FitzHugh-Nagumo network stepper.
`default_nettype none
package fnn_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int MAX_NEURONS = 64;
	localparam int NI_W        = $clog2(MAX_NEURONS);
	localparam int NC_W        = NI_W + 1;
	localparam int MAX_EDGES   = 256;
	localparam int EA_W        = $clog2(MAX_EDGES);
	localparam int EC_W        = EA_W + 1;
	// coupling accumulator: up to MAX_EDGES differences of 33 bits
	localparam int ACC_W       = 33 + EC_W;

	localparam int K_07 = ((7 << FRAC_BITS) + 5) / 10;
	localparam int K_08 = ((8 << FRAC_BITS) + 5) / 10;
	localparam int K_12 = ((12 << FRAC_BITS) + 5) / 10;

	localparam logic [6:0] NC_RESET = 7'd64;
	localparam logic [16:0] DT_RESET = 17'd3277;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_EDGE  = 2'd1,
		OP_STEP  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_DT   = 2'd0,
		REG_GAIN = 2'd1,
		REG_NC   = 2'd2
	} reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_REP_RD,
		S_REP_OUT,
		S_EDGE_RD,
		S_EDGE_FETCH,
		S_EDGE_ACC,
		S_UPD_RD,
		S_UPD_GO,
		S_UPD_WAIT
	} ctl_state_t;

	typedef enum logic [2:0] {
		M_IDLE,
		M_SQ,
		M_CUBE,
		M_GC,
		M_DIV,
		M_INC,
		M_DONE
	} math_state_t;

	// saturate to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sd2147483647) r = 32'sh7FFFFFFF;
		else if (x < -64'sd2147483648) r = 32'sh80000000;
		else r = x[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/fnn_cell_math.sv =====
// Multi-cycle Euler update of one neuron: cubic term, coupling, divide by three.
`default_nettype none
module fnn_cell_math (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic signed [31:0]              u_in,
	input  wire logic signed [31:0]              v_in,
	input  wire logic signed [fnn_pkg::ACC_W-1:0] acc_in,
	input  wire logic signed [31:0]              gain,
	input  wire logic [16:0]                     dt,
	output logic                                 done,
	output logic signed [31:0]                   u_new,
	output logic signed [31:0]                   v_new
);

	fnn_pkg::math_state_t mst_q, mst_d;

	logic signed [31:0] u_q, v_q, c_q, du_q;
	logic signed [63:0] p1_q;
	logic signed [49:0] p2_q;
	logic signed [36:0] pre_q;
	logic               neg_q;
	logic [35:0]        mag_q, quo_q;
	logic [1:0]         rem_q;
	logic [3:0]         cnt_q;

	logic signed [31:0] u2, u3, dv;
	logic signed [63:0] gc;
	logic signed [39:0] x;
	logic [5:0]         t;
	logic [11:0]        tq;
	logic [3:0]         qd;
	logic [5:0]         rem_n;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mst_q <= fnn_pkg::M_IDLE;
		else mst_q <= mst_d;
	end

	// next state
	always_comb begin
		mst_d = mst_q;
		unique case (mst_q)
			fnn_pkg::M_IDLE: if (start) mst_d = fnn_pkg::M_SQ;
			fnn_pkg::M_SQ:   mst_d = fnn_pkg::M_CUBE;
			fnn_pkg::M_CUBE: mst_d = fnn_pkg::M_GC;
			fnn_pkg::M_GC:   mst_d = fnn_pkg::M_DIV;
			fnn_pkg::M_DIV:  if (cnt_q == 4'd8) mst_d = fnn_pkg::M_INC;
			fnn_pkg::M_INC:  mst_d = fnn_pkg::M_DONE;
			fnn_pkg::M_DONE: mst_d = fnn_pkg::M_IDLE;
			default:         mst_d = fnn_pkg::M_IDLE;
		endcase
	end

	// stage arithmetic
	assign u2 = fnn_pkg::sat32(p1_q >>> fnn_pkg::FRAC_BITS);
	assign u3 = fnn_pkg::sat32(p1_q >>> fnn_pkg::FRAC_BITS);
	assign gc = p1_q >>> fnn_pkg::FRAC_BITS;
	assign x  = -40'(u_q) + 40'(fnn_pkg::K_07) - 40'(p2_q >>> fnn_pkg::FRAC_BITS);
	// one base-16 digit of the divide by three per cycle; x*43>>7 is x/3 below 48
	assign t     = {rem_q, mag_q[35:32]};
	assign tq    = 12'(t) * 12'd43;
	assign qd    = tq[10:7];
	assign rem_n = t - 6'(qd) * 6'd3;
	assign dv    = neg_q ? fnn_pkg::sat32(64'sd0 - 64'($signed({1'b0, quo_q})))
	                     : fnn_pkg::sat32(64'($signed({1'b0, quo_q})));

	always_ff @(posedge clk) begin
		unique case (mst_q)
			fnn_pkg::M_IDLE: begin
				u_q  <= u_in;
				v_q  <= v_in;
				c_q  <= fnn_pkg::sat32(64'(acc_in));
				p1_q <= 64'(u_in) * 64'(u_in);
			end
			fnn_pkg::M_SQ: p1_q <= 64'(u2) * 64'(u_q);
			fnn_pkg::M_CUBE: begin
				pre_q <= 37'(u_q) * 37'sd3 + 37'(v_q) * 37'sd3
				       - 37'(fnn_pkg::K_12) - 37'(u3);
				p1_q  <= 64'(gain) * 64'(c_q);
				p2_q  <= 50'(fnn_pkg::K_08) * 50'(v_q);
			end
			fnn_pkg::M_GC: begin
				du_q  <= fnn_pkg::sat32(64'(pre_q) - gc);
				neg_q <= x[39];
				mag_q <= x[39] ? 36'(40'sd2 - x) : 36'(x);
				quo_q <= '0;
				rem_q <= '0;
				cnt_q <= '0;
			end
			fnn_pkg::M_DIV: begin
				quo_q <= {quo_q[31:0], qd};
				mag_q <= {mag_q[31:0], 4'd0};
				rem_q <= rem_n[1:0];
				cnt_q <= cnt_q + 4'd1;
			end
			fnn_pkg::M_INC: begin
				p1_q <= 64'(du_q) * 64'($signed({1'b0, dt}));
				p2_q <= 50'(dv) * 50'($signed({1'b0, dt}));
			end
			default: ;
		endcase
	end

	// result, valid while done is high
	assign done  = (mst_q == fnn_pkg::M_DONE);
	assign u_new = fnn_pkg::sat32(64'(u_q) + (p1_q >>> fnn_pkg::FRAC_BITS));
	assign v_new = fnn_pkg::sat32(64'(v_q) + 64'(p2_q >>> fnn_pkg::FRAC_BITS));

endmodule
`default_nettype wire

// ===== rtl/fitzhugh_nagumo_network_step.sv =====
// Top level: FitzHugh-Nagumo network stepper with state and edge memories.
// Load, append and clear items each give one acknowledgement. A step item
// reports u for each of the N active neurons, then does a read-modify-write
// of the coupling memory for each stored edge (read, fetch, accumulate; a
// stale edge skips the accumulate), and then updates each active neuron.
// Reset clears u, v (per-entry valid bits) and the edge count at once.
`default_nettype none
module fitzhugh_nagumo_network_step (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// neuron_index[5:0], u_value[37:6], v_value[69:38], edge_target[75:70], zero pad
	input  wire logic [79:0] s_tdata,
	// operation[1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// out_index[5:0], out_u[37:6], zero pad
	output logic [39:0]      m_tdata,
	output logic             m_tlast,
	// status[1:0]
	output logic [1:0]       m_tuser,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int NI = fnn_pkg::NI_W;

	// configuration
	logic [16:0]        dt_q;
	logic signed [31:0] gain_q;
	logic [6:0]         nc_q;
	logic [fnn_pkg::NC_W-1:0] n_act;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q   <= fnn_pkg::DT_RESET;
			gain_q <= '0;
			nc_q   <= fnn_pkg::NC_RESET;
		end else if (cfg_valid) begin
			unique case (fnn_pkg::reg_t'(cfg_index))
				fnn_pkg::REG_DT:   dt_q   <= cfg_data[16:0];
				fnn_pkg::REG_GAIN: gain_q <= cfg_data;
				fnn_pkg::REG_NC:   nc_q   <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (nc_q == 7'd0) n_act = fnn_pkg::NC_W'(1);
		else if (nc_q > 7'(fnn_pkg::MAX_NEURONS)) n_act = fnn_pkg::NC_W'(fnn_pkg::MAX_NEURONS);
		else n_act = fnn_pkg::NC_W'(nc_q);
	end

	// input fields
	fnn_pkg::op_t       in_op;
	logic [NI-1:0]      in_idx, in_tgt;
	logic signed [31:0] in_u, in_v;
	assign in_op  = fnn_pkg::op_t'(s_tuser);
	assign in_idx = s_tdata[5:0];
	assign in_u   = s_tdata[37:6];
	assign in_v   = s_tdata[69:38];
	assign in_tgt = s_tdata[75:70];

	// memories
	logic signed [31:0]               fast_mem [fnn_pkg::MAX_NEURONS];
	logic signed [31:0]               slow_mem [fnn_pkg::MAX_NEURONS];
	logic signed [fnn_pkg::ACC_W-1:0] acc_mem  [fnn_pkg::MAX_NEURONS];
	logic [2*NI-1:0]                  edge_mem [fnn_pkg::MAX_EDGES];
	logic [fnn_pkg::MAX_NEURONS-1:0]  nv_q;

	fnn_pkg::ctl_state_t state_q, state_d;
	logic [NI-1:0]            j_q, src_q;
	logic [fnn_pkg::EC_W-1:0] e_q, ecnt_q;

	logic [NI-1:0] addr_a, addr_b, addr_acc;
	logic signed [31:0] rda_q, rdb_q, rds_q;
	logic va_q, vb_q;
	logic signed [fnn_pkg::ACC_W-1:0] rdacc_q;
	logic [2*NI-1:0] rde_q;
	logic signed [31:0] ua, ub, sv;

	logic nv_we, fs_we, acc_we, edge_we;
	logic [NI-1:0] fs_wa, acc_wa;
	logic signed [31:0] fu_wd, sv_wd;
	logic signed [fnn_pkg::ACC_W-1:0] acc_wd;

	logic math_start, math_done;
	logic signed [31:0] u_new, v_new;

	logic out_load, out_last;
	logic [NI-1:0] out_idx;
	logic signed [31:0] out_u;
	fnn_pkg::status_t out_st;
	logic ecnt_inc, ecnt_clr, j_last, e_last, edge_ok;
	logic in_fire, out_free;

	assign out_free = !m_tvalid || m_tready;
	assign s_tready = (state_q == fnn_pkg::S_IDLE) && out_free;
	assign in_fire  = s_tvalid && s_tready;
	assign j_last   = ({1'b0, j_q} == fnn_pkg::NC_W'(n_act - 1'b1));
	assign e_last   = (e_q + 1'b1 == ecnt_q);
	assign edge_ok  = ({1'b0, rde_q[2*NI-1:NI]} < n_act) && ({1'b0, rde_q[NI-1:0]} < n_act);

	// reads masked to zero for never-written entries
	assign ua = va_q ? rda_q : 32'sd0;
	assign ub = vb_q ? rdb_q : 32'sd0;
	assign sv = va_q ? rds_q : 32'sd0;

	// memory read and write ports
	always_ff @(posedge clk) begin
		rda_q   <= fast_mem[addr_a];
		rdb_q   <= fast_mem[addr_b];
		rds_q   <= slow_mem[addr_a];
		rdacc_q <= acc_mem[addr_acc];
		rde_q   <= edge_mem[e_q[fnn_pkg::EA_W-1:0]];
		va_q    <= nv_q[addr_a];
		vb_q    <= nv_q[addr_b];
		if (fs_we) begin
			fast_mem[fs_wa] <= fu_wd;
			slow_mem[fs_wa] <= sv_wd;
		end
		if (acc_we) acc_mem[acc_wa] <= acc_wd;
		if (edge_we) edge_mem[ecnt_q[fnn_pkg::EA_W-1:0]] <= {in_idx, in_tgt};
	end

	// state register and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fnn_pkg::S_IDLE;
			nv_q    <= '0;
			ecnt_q  <= '0;
			j_q     <= '0;
			e_q     <= '0;
			src_q   <= '0;
		end else begin
			state_q <= state_d;
			if (nv_we) nv_q[fs_wa] <= 1'b1;
			if (ecnt_clr) ecnt_q <= '0;
			else if (ecnt_inc) ecnt_q <= ecnt_q + 1'b1;
			unique case (state_q)
				fnn_pkg::S_IDLE: begin
					j_q <= '0;
					e_q <= '0;
				end
				fnn_pkg::S_REP_OUT:
					if (out_free) j_q <= j_last ? '0 : j_q + 1'b1;
				fnn_pkg::S_EDGE_FETCH: begin
					src_q <= rde_q[2*NI-1:NI];
					if (!edge_ok) e_q <= e_q + 1'b1;
				end
				fnn_pkg::S_EDGE_ACC: e_q <= e_q + 1'b1;
				fnn_pkg::S_UPD_WAIT: if (math_done) j_q <= j_q + 1'b1;
				default: ;
			endcase
		end
	end

	// next state, addresses, writes and output loading
	always_comb begin
		state_d    = state_q;
		addr_a     = j_q;
		addr_b     = j_q;
		addr_acc   = j_q;
		nv_we      = 1'b0;
		fs_we      = 1'b0;
		fs_wa      = j_q;
		fu_wd      = u_new;
		sv_wd      = v_new;
		acc_we     = 1'b0;
		acc_wa     = j_q;
		acc_wd     = '0;
		edge_we    = 1'b0;
		ecnt_inc   = 1'b0;
		ecnt_clr   = 1'b0;
		math_start = 1'b0;
		out_load   = 1'b0;
		out_idx    = '0;
		out_u      = '0;
		out_last   = 1'b1;
		out_st     = fnn_pkg::ST_OK;
		unique case (state_q)
			fnn_pkg::S_IDLE: if (in_fire) begin
				unique case (in_op)
					fnn_pkg::OP_LOAD: begin
						out_load = 1'b1;
						if ({1'b0, in_idx} < n_act) begin
							fs_we = 1'b1;
							nv_we = 1'b1;
							fs_wa = in_idx;
							fu_wd = in_u;
							sv_wd = in_v;
						end else begin
							out_st = fnn_pkg::ST_RANGE;
						end
					end
					fnn_pkg::OP_EDGE: begin
						out_load = 1'b1;
						if ({1'b0, in_idx} >= n_act || {1'b0, in_tgt} >= n_act)
							out_st = fnn_pkg::ST_RANGE;
						else if (ecnt_q == fnn_pkg::EC_W'(fnn_pkg::MAX_EDGES))
							out_st = fnn_pkg::ST_FULL;
						else begin
							edge_we  = 1'b1;
							ecnt_inc = 1'b1;
						end
					end
					fnn_pkg::OP_CLEAR: begin
						out_load = 1'b1;
						ecnt_clr = 1'b1;
					end
					fnn_pkg::OP_STEP: state_d = fnn_pkg::S_REP_RD;
					default: ;
				endcase
			end
			fnn_pkg::S_REP_RD: state_d = fnn_pkg::S_REP_OUT;
			fnn_pkg::S_REP_OUT: if (out_free) begin
				out_load = 1'b1;
				out_idx  = j_q;
				out_u    = ua;
				out_last = j_last;
				// clear the coupling sum as each neuron is reported
				acc_we   = 1'b1;
				if (j_last)
					state_d = (ecnt_q == '0) ? fnn_pkg::S_UPD_RD : fnn_pkg::S_EDGE_RD;
				else
					state_d = fnn_pkg::S_REP_RD;
			end
			fnn_pkg::S_EDGE_RD: state_d = fnn_pkg::S_EDGE_FETCH;
			fnn_pkg::S_EDGE_FETCH: begin
				addr_a   = rde_q[2*NI-1:NI];
				addr_b   = rde_q[NI-1:0];
				addr_acc = rde_q[2*NI-1:NI];
				if (edge_ok) state_d = fnn_pkg::S_EDGE_ACC;
				else state_d = e_last ? fnn_pkg::S_UPD_RD : fnn_pkg::S_EDGE_RD;
			end
			fnn_pkg::S_EDGE_ACC: begin
				acc_we  = 1'b1;
				acc_wa  = src_q;
				acc_wd  = rdacc_q + fnn_pkg::ACC_W'(ua) - fnn_pkg::ACC_W'(ub);
				state_d = e_last ? fnn_pkg::S_UPD_RD : fnn_pkg::S_EDGE_RD;
			end
			fnn_pkg::S_UPD_RD: state_d = fnn_pkg::S_UPD_GO;
			fnn_pkg::S_UPD_GO: begin
				math_start = 1'b1;
				state_d    = fnn_pkg::S_UPD_WAIT;
			end
			fnn_pkg::S_UPD_WAIT: if (math_done) begin
				fs_we   = 1'b1;
				nv_we   = 1'b1;
				state_d = j_last ? fnn_pkg::S_IDLE : fnn_pkg::S_UPD_RD;
			end
			default: state_d = fnn_pkg::S_IDLE;
		endcase
	end

	fnn_cell_math u_math (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (math_start),
		.u_in   (ua),
		.v_in   (sv),
		.acc_in (rdacc_q),
		.gain   (gain_q),
		.dt     (dt_q),
		.done   (math_done),
		.u_new  (u_new),
		.v_new  (v_new)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (out_load) m_tvalid <= 1'b1;
		else if (m_tready) m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= {2'b00, out_u, out_idx};
			m_tlast <= out_last;
			m_tuser <= out_st;
		end
	end

	// checks
	a_ecnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ecnt_q <= fnn_pkg::EC_W'(fnn_pkg::MAX_EDGES))
		else $error("edge count beyond table size");
	a_rep_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fnn_pkg::S_REP_OUT |-> {1'b0, j_q} < n_act)
		else $error("report index beyond active count");
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		math_done |-> state_q == fnn_pkg::S_UPD_WAIT)
		else $error("update result outside wait state");
	a_edge_src: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fnn_pkg::S_EDGE_ACC |-> {1'b0, src_q} < n_act)
		else $error("stale edge accumulated");

endmodule
`default_nettype wire

// ===== dv/fitzhugh_nagumo_network_step_checker.sv =====
// Scoreboard for the network stepper: mirrors neuron and edge state and checks every result.
`timescale 1ns / 100ps
`default_nettype none
module fitzhugh_nagumo_network_step_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [79:0] s_tdata,
	input  wire logic [1:0]  s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [39:0] m_tdata,
	input  wire logic        m_tlast,
	input  wire logic [1:0]  m_tuser,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output int               fail_count,
	output int               pending
);

	typedef struct packed {
		logic [5:0]  idx;
		logic [31:0] u;
		logic        last;
		logic [1:0]  status;
	} report_t;

	report_t report_q[$];

	logic signed [31:0] fast_mem[fnn_pkg::MAX_NEURONS];
	logic signed [31:0] slow_mem[fnn_pkg::MAX_NEURONS];
	logic [5:0]         src_mem[fnn_pkg::MAX_EDGES];
	logic [5:0]         dst_mem[fnn_pkg::MAX_EDGES];
	int                 n_edges;
	logic [16:0]        dt_reg;
	logic signed [31:0] gain_reg;
	logic [6:0]         count_reg;

	assign pending = report_q.size();

	function automatic longint clamp32(input longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// arithmetic shift is floor rounding
	function automatic longint qmul(input longint a, input longint b);
		return (a * b) >>> fnn_pkg::FRAC_BITS;
	endfunction

	function automatic longint div3_floor(input longint x);
		if (x >= 0) return x / 3;
		return -((-x + 2) / 3);
	endfunction

	function automatic int live_neurons();
		if (count_reg == 0) return 1;
		if (count_reg > fnn_pkg::MAX_NEURONS) return fnn_pkg::MAX_NEURONS;
		return count_reg;
	endfunction

	// append one expected transaction at the tail
	function automatic void add_report(input report_t r);
		report_q.insert(report_q.size(), r);
	endfunction

	function automatic void push_ack(input fnn_pkg::status_t st);
		report_t r;
		r.idx = '0; r.u = '0; r.last = 1'b1; r.status = st;
		add_report(r);
	endfunction

	// one input transaction: update mirrored state and queue the expected results
	task automatic predict_item(input fnn_pkg::op_t op, input logic [79:0] d);
		int n;
		logic [5:0] idx, tgt;
		longint acc[fnn_pkg::MAX_NEURONS];
		longint u, v, u2, u3, gc, du, dv;
		report_t r;
		n = live_neurons();
		idx = d[5:0];
		tgt = d[75:70];
		case (op)
			fnn_pkg::OP_LOAD: begin
				if (idx >= n) push_ack(fnn_pkg::ST_RANGE);
				else begin
					fast_mem[idx] = d[37:6];
					slow_mem[idx] = d[69:38];
					push_ack(fnn_pkg::ST_OK);
				end
			end
			fnn_pkg::OP_EDGE: begin
				if (idx >= n || tgt >= n) push_ack(fnn_pkg::ST_RANGE);
				else if (n_edges >= fnn_pkg::MAX_EDGES) push_ack(fnn_pkg::ST_FULL);
				else begin
					src_mem[n_edges] = idx;
					dst_mem[n_edges] = tgt;
					n_edges++;
					push_ack(fnn_pkg::ST_OK);
				end
			end
			fnn_pkg::OP_CLEAR: begin
				n_edges = 0;
				push_ack(fnn_pkg::ST_OK);
			end
			default: begin
				for (int j = 0; j < n; j++) begin
					r.idx = 6'(j); r.u = fast_mem[j]; r.last = (j == n - 1);
					r.status = fnn_pkg::ST_OK;
					add_report(r);
					acc[j] = 0;
				end
				// stale edges are skipped
				for (int e = 0; e < n_edges; e++)
					if (src_mem[e] < n && dst_mem[e] < n)
						acc[src_mem[e]] += longint'(fast_mem[src_mem[e]])
							- longint'(fast_mem[dst_mem[e]]);
				for (int j = 0; j < n; j++) begin
					u = fast_mem[j];
					v = slow_mem[j];
					u2 = clamp32(qmul(u, u));
					u3 = clamp32(qmul(u2, u));
					gc = qmul(longint'(gain_reg), clamp32(acc[j]));
					du = clamp32(3 * u - u3 + 3 * v - fnn_pkg::K_12 - gc);
					dv = clamp32(div3_floor(-u + fnn_pkg::K_07 - qmul(fnn_pkg::K_08, v)));
					fast_mem[j] = 32'(clamp32(u + qmul(du, longint'(dt_reg))));
					slow_mem[j] = 32'(clamp32(v + qmul(dv, longint'(dt_reg))));
				end
			end
		endcase
	endtask

	// monitor all channels
	always @(posedge clk or negedge arst_n) begin
		report_t got, want;
		if (!arst_n) begin
			for (int j = 0; j < fnn_pkg::MAX_NEURONS; j++) begin
				fast_mem[j] = 0;
				slow_mem[j] = 0;
			end
			n_edges = 0;
			dt_reg = fnn_pkg::DT_RESET;
			gain_reg = 0;
			count_reg = fnn_pkg::NC_RESET;
			fail_count = 0;
			report_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (fnn_pkg::reg_t'(cfg_index))
					fnn_pkg::REG_DT:   dt_reg = cfg_data[16:0];
					fnn_pkg::REG_GAIN: gain_reg = cfg_data;
					fnn_pkg::REG_NC:   count_reg = cfg_data[6:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) predict_item(fnn_pkg::op_t'(s_tuser), s_tdata);
			if (m_tvalid && m_tready) begin
				got.idx = m_tdata[5:0]; got.u = m_tdata[37:6];
				got.last = m_tlast; got.status = m_tuser;
				if (report_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%t unexpected result idx=%0d u=%h", $realtime,
							got.idx, got.u);
				end else begin
					want = report_q.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%t mismatch exp idx=%0d u=%h last=%b st=%0d %s%0d u=%h last=%b st=%0d",
								$realtime, want.idx, want.u, want.last, want.status,
								"got idx=", got.idx, got.u, got.last, got.status);
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== dv/fitzhugh_nagumo_network_step_test.sv =====
// Stimulus and verdict for the FitzHugh-Nagumo network stepper.
`timescale 1ns / 100ps
`default_nettype none
module fitzhugh_nagumo_network_step_test;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tlast;
	logic [1:0]  m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	int          fail_count;
	int          pending;
	int          idle_pct;
	int          stall_pct;
	int          live_n;

	fitzhugh_nagumo_network_step i_dut (.*);
	fitzhugh_nagumo_network_step_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("** fitzhugh_nagumo_network_step: FAILED **");
		$finish;
	end

	// receiver backpressure
	always @(posedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

	// random value biased toward extremes and the interesting range near zero
	function automatic logic [31:0] pick_q();
		case ($urandom_range(5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom;
			default: return $urandom_range(32'h30000) - 32'h18000;
		endcase
	endfunction

	// valid stays high between back-to-back transactions; it drops only for idle gaps
	task automatic send(input fnn_pkg::op_t op, input logic [5:0] idx, input logic [31:0] u,
			input logic [31:0] v, input logic [5:0] tgt);
		if ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {4'd0, tgt, v, u, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic write_reg(input fnn_pkg::reg_t r, input logic [31:0] d);
		s_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		// wait until every result is out and the block is idle again
		while (pending != 0 || !s_tready) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (r == fnn_pkg::REG_NC) live_n = (d[6:0] == 0) ? 1 : (d[6:0] > 64 ? 64 : d[6:0]);
	endtask

	task automatic rand_item(input int big);
		int k;
		k = $urandom_range(99);
		if (k < 40)
			send(fnn_pkg::OP_LOAD, 6'($urandom_range(live_n - 1 + (k < 3 ? 3 : 0))),
				pick_q(), pick_q(), 6'd0);
		else if (k < 80)
			send(fnn_pkg::OP_EDGE, 6'($urandom_range(live_n - 1 + (k < 43 ? 2 : 0))),
				pick_q(), pick_q(), 6'($urandom_range(live_n - 1 + (k == 79 ? 2 : 0))));
		else if (k < 95 || big)
			send(fnn_pkg::OP_STEP, 6'($urandom), $urandom, $urandom, 6'($urandom));
		else
			send(fnn_pkg::OP_CLEAR, 6'($urandom), $urandom, $urandom, 6'($urandom));
	endtask

	initial begin
		int waited;
		arst_n = 1'b0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = fnn_pkg::OP_LOAD;
		cfg_valid = 1'b0; cfg_index = fnn_pkg::REG_DT; cfg_data = '0;
		idle_pct = 0; stall_pct = 0; live_n = 64;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: step at reset defaults, loads at extremes, edges, overflow
		send(fnn_pkg::OP_STEP, 0, 0, 0, 0);
		write_reg(fnn_pkg::REG_NC, 4);
		send(fnn_pkg::OP_LOAD, 0, 32'h7FFFFFFF, 32'h80000000, 0);
		send(fnn_pkg::OP_LOAD, 1, 32'h80000000, 32'h7FFFFFFF, 63);
		send(fnn_pkg::OP_LOAD, 2, 32'h00010000, 32'hFFFF0000, 0);
		send(fnn_pkg::OP_LOAD, 3, 32'hFFFFFFFF, 32'hFFFFFFFF, 0);
		send(fnn_pkg::OP_LOAD, 63, 32'h1234, 32'h5678, 0);
		send(fnn_pkg::OP_EDGE, 0, 0, 0, 1);
		send(fnn_pkg::OP_EDGE, 0, 0, 0, 1);
		send(fnn_pkg::OP_EDGE, 2, 0, 0, 3);
		send(fnn_pkg::OP_EDGE, 3, 0, 0, 2);
		send(fnn_pkg::OP_EDGE, 4, 0, 0, 0);
		send(fnn_pkg::OP_EDGE, 0, 0, 0, 63);
		write_reg(fnn_pkg::REG_GAIN, 32'h80000000);
		write_reg(fnn_pkg::REG_DT, 17'h10000);
		send(fnn_pkg::OP_STEP, 0, 0, 0, 0);
		write_reg(fnn_pkg::REG_GAIN, 32'h7FFFFFFF);
		write_reg(fnn_pkg::REG_DT, 0);
		send(fnn_pkg::OP_STEP, 0, 0, 0, 0);
		write_reg(fnn_pkg::REG_NC, 2); // edges 2->3 and 3->2 are now stale
		write_reg(fnn_pkg::REG_DT, 17'h1FFFF);
		send(fnn_pkg::OP_STEP, 0, 0, 0, 0);
		write_reg(fnn_pkg::REG_NC, 0);
		send(fnn_pkg::OP_LOAD, 1, 1, 1, 0);
		send(fnn_pkg::OP_STEP, 0, 0, 0, 0);
		write_reg(fnn_pkg::REG_NC, 7'h7F);
		write_reg(fnn_pkg::REG_GAIN, 32'h00008000);
		write_reg(fnn_pkg::REG_DT, 3277);
		// fill the edge table past full
		for (int e = 0; e < fnn_pkg::MAX_EDGES + 2; e++)
			send(fnn_pkg::OP_EDGE, 6'($urandom), 0, 0, 6'($urandom));
		send(fnn_pkg::OP_STEP, 0, 0, 0, 0);
		send(fnn_pkg::OP_CLEAR, 0, 0, 0, 0);

		// random phases with different pressure and settings
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(fnn_pkg::REG_NC, (ph == 3) ? 64 : $urandom_range(1, 12));
			write_reg(fnn_pkg::REG_GAIN, pick_q());
			write_reg(fnn_pkg::REG_DT, (ph == 1) ? 17'h10000 : $urandom_range(200, 8000));
			idle_pct = (ph == 1 || ph == 3) ? 69 : 0;
			stall_pct = (ph == 2 || ph == 3) ? 69 : 0;
			if (ph == 3) begin idle_pct = 12; stall_pct = 12; end
			for (int i = 0; i < ((ph == 3) ? 20 : 25); i++) rand_item(0);
		end
		s_tvalid <= 1'b0;

		waited = 0;
		while (pending != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (1500) @(posedge clk);
		if (pending == 0 && fail_count == 0)
			$display("** fitzhugh_nagumo_network_step: PASSED **");
		else
			$display("** fitzhugh_nagumo_network_step: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/fnn_pkg.sv
rtl/fnn_cell_math.sv
rtl/fitzhugh_nagumo_network_step.sv
dv/fitzhugh_nagumo_network_step_checker.sv
dv/fitzhugh_nagumo_network_step_test.sv
